// ----- src/assert_macros.svh -----
// Assertion macros shared by the voice allocator RTL.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/sva_pkg.sv -----
// Shared types, codes and constants for the voice allocator.
// No dependencies; used by every module of the block.
`default_nettype none
package sva_pkg;

  localparam int MAX_VOICES_DEF  = 16;
  localparam int STACK_DEPTH_DEF = 128;
  localparam int RES_CAP         = 16;

  localparam int NOTE_W  = 7;
  localparam int VEL_W   = 7;
  localparam int CH_W    = 4;
  localparam int VOICE_W = 4;
  localparam int STAMP_W = 32;
  localparam int MODE_W  = 3;
  localparam int VIU_W   = 5;
  localparam int FUNC_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [MODE_W-1:0] MODE_POLY      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CHAN      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MONO_LAST = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MONO_LOW  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MONO_HIGH = 3'd4;

  localparam logic [FUNC_W-1:0] FN_NOTE_ON  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_NOTE_OFF = 2'd1;
  localparam logic [FUNC_W-1:0] FN_RELEASE  = 2'd2;
  localparam logic [FUNC_W-1:0] FN_ALL_OFF  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ALLOC_MODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VOICES_IN_USE = 1'b1;

  typedef enum logic [1:0] {
    SOP_NONE,
    SOP_PUSH,
    SOP_REMOVE,
    SOP_CLEAR
  } stk_op_t;

  typedef struct packed {
    logic              start;
    stk_op_t           op;
    logic [NOTE_W-1:0] key;
    logic [MODE_W-1:0] mode;
  } stk_cmd_t;

  typedef struct packed {
    logic              busy;
    logic              has;
    logic [NOTE_W-1:0] note;
  } stk_stat_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [CH_W-1:0]    midi_channel;
    logic [NOTE_W-1:0]  note_number;
    logic [VEL_W-1:0]   note_velocity;
    logic [VOICE_W-1:0] release_index;
  } in_t;

  typedef struct packed {
    logic [VOICE_W-1:0] voice;
    logic               voice_valid;
    logic [NOTE_W-1:0]  voice_note;
    logic [VEL_W-1:0]   voice_velocity;
    logic               last;
    logic [NOTE_W-1:0]  mono_note;
    logic               mono_valid;
  } out_t;

  function automatic logic is_mono(input logic [MODE_W-1:0] mode);
    return (mode == MODE_MONO_LAST) || (mode == MODE_MONO_LOW) || (mode == MODE_MONO_HIGH);
  endfunction

endpackage
`default_nettype wire

// ----- src/synth_voice_allocator.sv -----
// Voice allocator top level: voice table, event sequencer and result output.
// Depends on sva_pkg, sva_held_stack and assert_macros.svh.
//
// Channels: an event word enters on in_valid/in_ready; result words leave on
// out_valid/out_ready; cfg_valid/cfg_ready writes alloc_mode (index 0) or
// voices_in_use (index 1), and is always ready.
// Every event gives one or more result words; the final one has last set.
// Note-off in polyphonic mode gives one word per released voice, at most 16.
// Per event, from acceptance to the final word: decode and output, the
// polyphonic voice scan over the N voices in use with a release step for
// each released voice, the channel modulo by repeated subtraction, and in
// mono modes one run of the held notes through the cell chain (depth up to
// STACK_DEPTH). One event is in flight.
// in_ready is high whenever the sequencer is idle, even while the last
// result word still waits in the output register.
// When the receiver stalls, hold the word in the output register; a
// polyphonic release scan stops until its previous word has left.
// Reset clears the voice table, the stamp counter, the stack depth and the
// configuration (polyphonic mode, 16 voices); no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"
module synth_voice_allocator #(
  parameter int MAX_VOICES  = sva_pkg::MAX_VOICES_DEF,
  parameter int STACK_DEPTH = sva_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire sva_pkg::in_t                    in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output sva_pkg::out_t                        out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [sva_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sva_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sva_pkg::*;

  localparam int NW = $clog2(MAX_VOICES + 1);
  localparam int VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int RCW = $clog2(RES_CAP + 1);

  // sequencer state codes
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MOD   = 4'd1;
  localparam logic [3:0] ST_SCAN  = 4'd2;
  localparam logic [3:0] ST_CHK   = 4'd3;
  localparam logic [3:0] ST_ALLOC = 4'd4;
  localparam logic [3:0] ST_REL   = 4'd5;
  localparam logic [3:0] ST_CLR   = 4'd6;
  localparam logic [3:0] ST_POST  = 4'd7;
  localparam logic [3:0] ST_WAIT  = 4'd8;
  localparam logic [3:0] ST_FINAL = 4'd9;

  // configuration
  logic [MODE_W-1:0] alloc_mode;
  logic [VIU_W-1:0]  voices_in_use;

  // voice table
  logic               act    [MAX_VOICES];
  logic [NOTE_W-1:0]  vnote  [MAX_VOICES];
  logic [VEL_W-1:0]   vvel   [MAX_VOICES];
  logic [CH_W-1:0]    vch    [MAX_VOICES];
  logic [STAMP_W-1:0] vstamp [MAX_VOICES];
  logic [STAMP_W-1:0] stamp_counter;

  // sequencer
  logic [3:0]         state;
  in_t                cur;
  logic [NW-1:0]      idx;
  logic [VW-1:0]      best_idx;
  logic [STAMP_W-1:0] best_stamp;
  logic [VW-1:0]      v_sel;
  logic [CH_W-1:0]    r;
  logic               rel_from_scan;
  logic               pend_v;
  logic [VW-1:0]      pend_voice;
  logic [NOTE_W-1:0]  pend_note;
  logic [VEL_W-1:0]   pend_vel;
  logic [RCW-1:0]     rec_cnt;
  stk_op_t            stk_op;
  logic [NOTE_W-1:0]  stk_key;

  logic [NW-1:0]      n;
  logic [VW-1:0]      rd;
  logic               out_free;
  logic               out_load;
  logic               mono;
  logic               rel_stall;
  logic               rec_room;
  logic [7:0]         r8;
  logic [7:0]         n8;
  logic               need_stack;
  stk_cmd_t           stk_cmd;
  stk_stat_t          stk_stat;

  // clamp the voice count to 1..MAX_VOICES
  always_comb begin
    if (voices_in_use == '0) begin
      n = NW'(1);
    end else if (32'(voices_in_use) > MAX_VOICES) begin
      n = NW'(MAX_VOICES);
    end else begin
      n = NW'(voices_in_use);
    end
  end

  assign mono       = is_mono(alloc_mode);
  assign rd         = (state == ST_SCAN) ? idx[VW-1:0] : v_sel;
  assign out_free   = !out_valid || out_ready;
  assign rec_room   = rec_cnt < RCW'(RES_CAP);
  assign rel_stall  = rec_room && pend_v && !out_free;
  // a new word enters the output register this cycle
  assign out_load   = ((state == ST_REL) && !rel_stall && rec_room && pend_v) ||
                      ((state == ST_FINAL) && out_free);
  assign r8         = 8'(r);
  assign n8         = 8'(n);
  assign need_stack = mono || (stk_op == SOP_CLEAR);
  assign in_ready   = state == ST_IDLE;
  assign cfg_ready  = 1'b1;

  always_comb begin
    stk_cmd.start = (state == ST_POST) && need_stack;
    stk_cmd.op    = stk_op;
    stk_cmd.key   = stk_key;
    stk_cmd.mode  = alloc_mode;
  end

  sva_held_stack #(
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk (clk),
    .rst (rst),
    .cmd (stk_cmd),
    .stat(stk_stat)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      alloc_mode    <= MODE_POLY;
      voices_in_use <= VIU_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ALLOC_MODE:    alloc_mode    <= cfg_data[MODE_W-1:0];
        REG_VOICES_IN_USE: voices_in_use <= cfg_data[VIU_W-1:0];
        default: ;
      endcase
    end
  end

  // event sequencer, voice table and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      stamp_counter <= '0;
      pend_v        <= 1'b0;
      rec_cnt       <= '0;
      stk_op        <= SOP_NONE;
      for (int i = 0; i < MAX_VOICES; i++) begin
        act[i]    <= 1'b0;
        vnote[i]  <= '0;
        vvel[i]   <= '0;
        vch[i]    <= '0;
        vstamp[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            cur           <= in_data;
            idx           <= '0;
            rec_cnt       <= '0;
            pend_v        <= 1'b0;
            stk_op        <= SOP_NONE;
            r             <= in_data.midi_channel;
            rel_from_scan <= 1'b0;
            unique case (in_data.func)
              FN_NOTE_ON: begin
                if (alloc_mode == MODE_POLY) begin
                  state <= ST_SCAN;
                end else if (alloc_mode == MODE_CHAN) begin
                  state <= ST_MOD;
                end else if (mono) begin
                  v_sel <= '0;
                  state <= ST_ALLOC;
                end else begin
                  state <= ST_POST;
                end
              end
              FN_NOTE_OFF: begin
                if (alloc_mode == MODE_POLY) begin
                  state <= ST_SCAN;
                end else if (alloc_mode == MODE_CHAN) begin
                  state <= ST_MOD;
                end else if (mono) begin
                  v_sel <= '0;
                  state <= ST_CHK;
                end else begin
                  state <= ST_POST;
                end
              end
              FN_RELEASE: begin
                if (8'(in_data.release_index) < 8'(n)) begin
                  v_sel <= VW'(in_data.release_index);
                  state <= ST_REL;
                end else begin
                  state <= ST_POST;
                end
              end
              FN_ALL_OFF: state <= ST_CLR;
              default: state <= ST_POST;
            endcase
          end
        end
        // channel modulo voice count, one subtract per cycle
        ST_MOD: begin
          if (r8 >= n8) begin
            r <= CH_W'(r8 - n8);
          end else begin
            v_sel <= VW'(r);
            state <= (cur.func == FN_NOTE_ON) ? ST_ALLOC : ST_CHK;
          end
        end
        // polyphonic scan: first idle voice or oldest stamp, or note-off match
        ST_SCAN: begin
          if (idx == n) begin
            if (cur.func == FN_NOTE_ON) begin
              v_sel <= best_idx;
              state <= ST_ALLOC;
            end else begin
              state <= ST_POST;
            end
          end else if (cur.func == FN_NOTE_ON) begin
            if (!act[rd]) begin
              v_sel <= rd;
              state <= ST_ALLOC;
            end else begin
              if (idx == '0 || vstamp[rd] < best_stamp) begin
                best_idx   <= rd;
                best_stamp <= vstamp[rd];
              end
              idx <= idx + NW'(1);
            end
          end else if (act[rd] && vnote[rd] == cur.note_number) begin
            v_sel         <= rd;
            rel_from_scan <= 1'b1;
            state         <= ST_REL;
          end else begin
            idx <= idx + NW'(1);
          end
        end
        ST_CHK: begin
          if (act[rd] && vnote[rd] == cur.note_number &&
              (alloc_mode != MODE_CHAN || vch[rd] == cur.midi_channel)) begin
            state <= ST_REL;
          end else begin
            state <= ST_POST;
          end
        end
        ST_ALLOC: begin
          act[v_sel]    <= 1'b1;
          vnote[v_sel]  <= cur.note_number;
          vvel[v_sel]   <= cur.note_velocity;
          vch[v_sel]    <= cur.midi_channel;
          vstamp[v_sel] <= stamp_counter;
          stamp_counter <= stamp_counter + STAMP_W'(1);
          pend_v        <= 1'b1;
          pend_voice    <= v_sel;
          pend_note     <= cur.note_number;
          pend_vel      <= cur.note_velocity;
          rec_cnt       <= RCW'(1);
          if (mono) begin
            stk_op  <= SOP_PUSH;
            stk_key <= cur.note_number;
          end
          state <= ST_POST;
        end
        // release one voice; flush the previous word before holding this one
        ST_REL: begin
          if (!rel_stall) begin
            if (rec_room) begin
              if (pend_v) begin
                out_valid                <= 1'b1;
                out_data.voice           <= VOICE_W'(pend_voice);
                out_data.voice_valid     <= 1'b1;
                out_data.voice_note      <= pend_note;
                out_data.voice_velocity  <= pend_vel;
                out_data.last            <= 1'b0;
                out_data.mono_note       <= '0;
                out_data.mono_valid      <= 1'b0;
              end
              pend_v     <= 1'b1;
              pend_voice <= v_sel;
              pend_note  <= vnote[rd];
              pend_vel   <= vvel[rd];
              rec_cnt    <= rec_cnt + RCW'(1);
            end
            if (mono) begin
              stk_op  <= SOP_REMOVE;
              stk_key <= vnote[rd];
            end
            act[v_sel]   <= 1'b0;
            vnote[v_sel] <= '0;
            vvel[v_sel]  <= '0;
            if (rel_from_scan) begin
              idx   <= idx + NW'(1);
              state <= ST_SCAN;
            end else begin
              state <= ST_POST;
            end
          end
        end
        ST_CLR: begin
          for (int i = 0; i < MAX_VOICES; i++) begin
            if (NW'(i) < n) begin
              act[i]   <= 1'b0;
              vnote[i] <= '0;
              vvel[i]  <= '0;
            end
          end
          stk_op <= SOP_CLEAR;
          state  <= ST_POST;
        end
        ST_POST: begin
          state <= need_stack ? ST_WAIT : ST_FINAL;
        end
        ST_WAIT: begin
          if (!stk_stat.busy) begin
            state <= ST_FINAL;
          end
        end
        // final word of the event carries last and the mono note
        ST_FINAL: begin
          if (out_free) begin
            out_valid               <= 1'b1;
            out_data.voice          <= pend_v ? VOICE_W'(pend_voice) : '0;
            out_data.voice_valid    <= pend_v;
            out_data.voice_note     <= pend_v ? pend_note : '0;
            out_data.voice_velocity <= pend_v ? pend_vel : '0;
            out_data.last           <= 1'b1;
            out_data.mono_valid     <= mono && stk_stat.has;
            out_data.mono_note      <= (mono && stk_stat.has) ? stk_stat.note : '0;
            state                   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_mono_only_in_mono, out_valid && out_data.mono_valid, mono, "mono note outside mono mode")
  `ASSERT_IMPLIES(a_stack_busy_waits, stk_stat.busy, state == ST_WAIT, "stack busy while sequencer not waiting")
  `ASSERT_IMPLIES(a_rec_cap, 1'b1, rec_cnt <= RCW'(RES_CAP), "result count above cap")
  `ASSERT_IMPLIES(a_empty_is_last, out_valid && !out_data.voice_valid, out_data.last, "empty result word not last")

endmodule
`default_nettype wire

// ----- src/sva_stack_cell.sv -----
// One entry of the held-note chain: load a note or take the neighbor's.
// Depends on sva_pkg.
`default_nettype none
module sva_stack_cell (
  input  wire logic                      clk,
  input  wire logic                      shift,
  input  wire logic                      load,
  input  wire logic [sva_pkg::NOTE_W-1:0] load_data,
  input  wire logic [sva_pkg::NOTE_W-1:0] next_in,
  output logic      [sva_pkg::NOTE_W-1:0] note
);
  import sva_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      note <= load_data;
    end else if (shift) begin
      note <= next_in;
    end
  end

endmodule
`default_nettype wire

// ----- src/sva_held_stack.sv -----
// Held-note stack for the mono modes: a chain of cells rotated through one
// head processor that removes, checks duplicates and ranks notes.
// Depends on sva_pkg and sva_stack_cell.
`default_nettype none
module sva_held_stack #(
  parameter int DEPTH = sva_pkg::STACK_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sva_pkg::stk_cmd_t  cmd,
  output sva_pkg::stk_stat_t      stat
);
  import sva_pkg::*;

  localparam int DW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] SS_IDLE = 2'd0;
  localparam logic [1:0] SS_PASS = 2'd1;
  localparam logic [1:0] SS_TAIL = 2'd2;

  logic [1:0]        state;
  logic [DW-1:0]     depth;
  logic [DW-1:0]     cnt;
  logic [DW-1:0]     steps;
  stk_op_t           op;
  logic [NOTE_W-1:0] key;
  logic [MODE_W-1:0] mode;
  logic              found;
  logic              removed;
  logic              has;
  logic [NOTE_W-1:0] best;
  logic [NOTE_W-1:0] top;

  logic [NOTE_W-1:0] cell_q [DEPTH];
  logic [DEPTH-1:0]  load_vec;
  logic              shift_all;
  logic              load_en;
  logic [NOTE_W-1:0] load_data;
  logic [IW-1:0]     wr_idx;
  logic [DW-1:0]     cnt_m1;
  logic [NOTE_W-1:0] head;
  logic              step;
  logic              drop;
  logic              push_ok;
  logic              incl;
  logic [NOTE_W-1:0] incl_val;
  logic              better;

  assign head    = cell_q[0];
  assign step    = (state == SS_PASS) && (steps != '0);
  assign drop    = (op == SOP_REMOVE) && !removed && (head == key);
  assign push_ok = (state == SS_TAIL) && (op == SOP_PUSH) && !found && (cnt < DW'(DEPTH));
  assign cnt_m1  = cnt - DW'(1);

  always_comb begin
    shift_all = step;
    load_en   = (step && !drop) || push_ok;
    load_data = step ? head : key;
    wr_idx    = step ? cnt_m1[IW-1:0] : cnt[IW-1:0];
    incl      = (step && !drop) || push_ok;
    incl_val  = step ? head : key;
    if (mode == MODE_MONO_LOW) begin
      better = incl_val < best;
    end else begin
      better = incl_val > best;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    assign load_vec[g] = load_en && (wr_idx == IW'(g));
    if (g == DEPTH - 1) begin : g_end
      sva_stack_cell u_cell (
        .clk      (clk),
        .shift    (shift_all),
        .load     (load_vec[g]),
        .load_data(load_data),
        .next_in  (cell_q[0]),
        .note     (cell_q[g])
      );
    end else begin : g_mid
      sva_stack_cell u_cell (
        .clk      (clk),
        .shift    (shift_all),
        .load     (load_vec[g]),
        .load_data(load_data),
        .next_in  (cell_q[g+1]),
        .note     (cell_q[g])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SS_IDLE;
      depth <= '0;
      has   <= 1'b0;
    end else begin
      unique case (state)
        SS_IDLE: begin
          if (cmd.start) begin
            op   <= cmd.op;
            key  <= cmd.key;
            mode <= cmd.mode;
            if (cmd.op == SOP_CLEAR) begin
              depth <= '0;
              has   <= 1'b0;
            end else begin
              cnt     <= depth;
              steps   <= depth;
              found   <= 1'b0;
              removed <= 1'b0;
              has     <= 1'b0;
              state   <= SS_PASS;
            end
          end
        end
        SS_PASS: begin
          if (steps == '0) begin
            state <= SS_TAIL;
          end else begin
            steps <= steps - DW'(1);
            if (head == key) begin
              found <= 1'b1;
            end
            if (drop) begin
              removed <= 1'b1;
              cnt     <= cnt_m1;
            end
          end
        end
        SS_TAIL: begin
          depth <= push_ok ? cnt + DW'(1) : cnt;
          state <= SS_IDLE;
        end
        default: state <= SS_IDLE;
      endcase
      if (incl) begin
        top <= incl_val;
        if (!has || better) begin
          best <= incl_val;
        end
        has <= 1'b1;
      end
    end
  end

  always_comb begin
    stat.busy = state != SS_IDLE;
    stat.has  = has;
    stat.note = (mode == MODE_MONO_LAST) ? top : best;
  end

endmodule
`default_nettype wire
